>>> src/pnte_pkg.sv
// Shared types and constants of the Petri net token engine.
// Depends on nothing; imported by the engine, its arc memory and its checker.
package pnte_pkg;

  localparam int CMD_W      = 3;
  localparam int IDX_W      = 4;
  localparam int WEIGHT_W   = 8;
  localparam int TOKENS_O_W = 8;

  // Command codes carried in the request tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_SET_IN    = 3'd0,
    CMD_SET_OUT   = 3'd1,
    CMD_ADD_TOKEN = 3'd2,
    CMD_QUERY     = 3'd3,
    CMD_FIRE      = 3'd4
  } cmd_e;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_SKIPPED = 1'b1;

  // One request as held in the input register.
  typedef struct packed {
    cmd_e                cmd;
    logic [IDX_W-1:0]    place;
    logic [IDX_W-1:0]    trans;
    logic [WEIGHT_W-1:0] weight;
  } req_t;

  // Read or write port control of the arc weight memory.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] trans;
  } arc_port_t;

endpackage

>>> src/petri_net_token_engine.sv
// Top level of the Petri net token engine: input register, arc memory,
// token counters and result register. Depends on pnte_pkg and pnte_arc_mem.
//
// Usage: requests enter on the s_axis channel, one per accepted handshake.
// The command code rides in s_axis_tuser; the place index, transition index
// and arc weight ride in s_axis_tdata. Every request yields exactly one
// result on the m_axis channel: the enabled flag of the addressed transition
// as it stood before the request, the skip status of a firing, and the token
// count of the addressed place after the request.
// Throughput is one request per cycle while the receiver does not stall.
// The accept edge loads the input register and the transition's weight row
// from the arc memory; when the request leaves the input register, the enable
// check and the token update run over all places in parallel and load the
// result register. A write to the row read by the next request is forwarded,
// so back-to-back requests on one transition see fresh weights.
// Reset clears the token counts and the row valid bits of the arc memory at
// once, so all weights read as zero; no clearing pass is needed.
// When the receiver stalls, the result holds in the result register, the
// following request waits in the input register, and s_axis_tready drops
// only while both are full.
module petri_net_token_engine
  import pnte_pkg::*;
#(
  parameter int NUM_PLACES      = 16,
  parameter int NUM_TRANSITIONS = 16,
  parameter int COUNT_BITS      = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] place_index, [7:4] transition_index, [15:8] arc_weight
  input  logic [15:0] s_axis_tdata,
  // [2:0] cmd
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] enabled, [1] status, [9:2] place_tokens, [15:10] zero
  output logic [15:0] m_axis_tdata
);

  localparam int PW    = NUM_PLACES * WEIGHT_W;
  localparam int ROW_W = 2 * PW;
  // Wide enough for a count plus a weight without overflow.
  localparam int CW    = ((COUNT_BITS > WEIGHT_W) ? COUNT_BITS : WEIGHT_W) + 1;
  localparam logic [CW-1:0] COUNT_MAX = CW'((1 << COUNT_BITS) - 1);

  function automatic logic [CW-1:0] sat(input logic [CW-1:0] s);
    return (s > COUNT_MAX) ? COUNT_MAX : s;
  endfunction

  // Request decode and handshake.
  req_t req_in;
  logic accept;
  logic out_free;
  logic s1_adv;

  assign req_in.cmd    = cmd_e'(s_axis_tuser);
  assign req_in.place  = s_axis_tdata[3:0];
  assign req_in.trans  = s_axis_tdata[7:4];
  assign req_in.weight = s_axis_tdata[15:8];

  // Input register stage.
  logic s1_vld_q;
  req_t s1_q;

  // Result register stage.
  logic                  out_vld_q;
  logic                  enabled_q;
  logic                  status_q;
  logic [TOKENS_O_W-1:0] tokens_o_q;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s1_adv        = s1_vld_q && out_free;
  assign s_axis_tready = !s1_vld_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Token counters, one per place.
  logic [COUNT_BITS-1:0] tok_q [NUM_PLACES];
  logic [COUNT_BITS-1:0] tok_d [NUM_PLACES];

  // Arc memory hookup.
  arc_port_t        rd_port;
  arc_port_t        wr_port;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] wr_row;

  logic p_ok;
  logic t_ok;
  logic arc_cmd;
  logic en;
  logic status;
  logic [TOKENS_O_W-1:0] tokens_o;

  assign p_ok    = 32'(s1_q.place) < 32'(NUM_PLACES);
  assign t_ok    = 32'(s1_q.trans) < 32'(NUM_TRANSITIONS);
  assign arc_cmd = (s1_q.cmd == CMD_SET_IN) || (s1_q.cmd == CMD_SET_OUT);

  assign rd_port.en    = accept;
  assign rd_port.trans = req_in.trans;
  assign wr_port.en    = s1_adv && arc_cmd && p_ok && t_ok;
  assign wr_port.trans = s1_q.trans;

  pnte_arc_mem #(
    .NUM_PLACES     (NUM_PLACES),
    .NUM_TRANSITIONS(NUM_TRANSITIONS)
  ) u_arc_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (rd_port),
    .wr_i    (wr_port),
    .wr_row_i(wr_row),
    .row_o   (row)
  );

  // The transition is enabled when every place holds at least its input weight.
  always_comb begin
    en = t_ok;
    for (int p = 0; p < NUM_PLACES; p++) begin
      if (CW'(tok_q[p]) < CW'(row[p*WEIGHT_W +: WEIGHT_W])) begin
        en = 1'b0;
      end
    end
  end

  // Row update for arc commands: replace the addressed place's weight.
  always_comb begin
    wr_row = row;
    for (int p = 0; p < NUM_PLACES; p++) begin
      if (32'(s1_q.place) == 32'(p)) begin
        if (s1_q.cmd == CMD_SET_IN) begin
          wr_row[p*WEIGHT_W +: WEIGHT_W] = s1_q.weight;
        end else begin
          wr_row[PW + p*WEIGHT_W +: WEIGHT_W] = s1_q.weight;
        end
      end
    end
  end

  // Token update over all places in parallel.
  always_comb begin
    logic [CW-1:0] t_ext;
    logic [CW-1:0] left;
    logic [CW-1:0] sum;
    for (int p = 0; p < NUM_PLACES; p++) begin
      t_ext    = CW'(tok_q[p]);
      left     = t_ext - CW'(row[p*WEIGHT_W +: WEIGHT_W]);
      sum      = sat(left + CW'(row[PW + p*WEIGHT_W +: WEIGHT_W]));
      tok_d[p] = tok_q[p];
      case (s1_q.cmd)
        CMD_ADD_TOKEN: begin
          if (p_ok && (32'(s1_q.place) == 32'(p))) begin
            tok_d[p] = COUNT_BITS'(sat(t_ext + CW'(1)));
          end
        end
        CMD_FIRE: begin
          if (en) begin
            tok_d[p] = COUNT_BITS'(sum);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result fields.
  always_comb begin
    logic [31:0] sel;
    sel = '0;
    for (int p = 0; p < NUM_PLACES; p++) begin
      if (32'(s1_q.place) == 32'(p)) begin
        sel = 32'(tok_d[p]);
      end
    end
    tokens_o = sel[TOKENS_O_W-1:0];
    status   = ((s1_q.cmd == CMD_FIRE) && !en) ? STATUS_SKIPPED : STATUS_DONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int p = 0; p < NUM_PLACES; p++) begin
        tok_q[p] <= '0;
      end
    end else begin
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
        for (int p = 0; p < NUM_PLACES; p++) begin
          tok_q[p] <= tok_d[p];
        end
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= req_in;
    end
    if (s1_adv) begin
      enabled_q  <= en;
      status_q   <= status;
      tokens_o_q <= tokens_o;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, tokens_o_q, status_q, enabled_q};

endmodule

>>> src/pnte_arc_mem.sv
// Arc weight memory: one row per transition holding the input and output
// weights of all places, with per-row valid bits and write-to-read bypass.
// Depends on pnte_pkg.
module pnte_arc_mem
  import pnte_pkg::*;
#(
  parameter int NUM_PLACES      = 16,
  parameter int NUM_TRANSITIONS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  arc_port_t                            rd_i,
  input  arc_port_t                            wr_i,
  input  logic [2*NUM_PLACES*WEIGHT_W-1:0]     wr_row_i,
  output logic [2*NUM_PLACES*WEIGHT_W-1:0]     row_o
);

  localparam int ROW_W = 2 * NUM_PLACES * WEIGHT_W;
  localparam int TA    = (NUM_TRANSITIONS > 1) ? $clog2(NUM_TRANSITIONS) : 1;

  logic [ROW_W-1:0]           mem_q [NUM_TRANSITIONS];
  logic [ROW_W-1:0]           rd_row_q;
  logic [ROW_W-1:0]           byp_row_q;
  logic [NUM_TRANSITIONS-1:0] vld_q;
  logic                       rd_vld_q;
  logic                       hit_q;

  logic [31:0]   rd_ext;
  logic [31:0]   wr_ext;
  logic [TA-1:0] rd_addr;
  logic [TA-1:0] wr_addr;
  logic          rd_in_range;
  logic          hit;

  assign rd_ext      = 32'(rd_i.trans);
  assign wr_ext      = 32'(wr_i.trans);
  assign rd_addr     = rd_ext[TA-1:0];
  assign wr_addr     = wr_ext[TA-1:0];
  assign rd_in_range = rd_ext < 32'(NUM_TRANSITIONS);
  // A row written in the same cycle as it is read is taken from the write data.
  assign hit         = rd_i.en && wr_i.en && (rd_i.trans == wr_i.trans);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr] <= wr_row_i;
    end
    if (rd_i.en && rd_in_range) begin
      rd_row_q <= mem_q[rd_addr];
    end
    if (rd_i.en) begin
      byp_row_q <= wr_row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_vld_q <= rd_in_range && vld_q[rd_addr];
        hit_q    <= hit;
      end
    end
  end

  // Rows never written read as zero weights.
  assign row_o = hit_q ? byp_row_q : (rd_vld_q ? rd_row_q : '0);

endmodule

>>> src/pnte_checker.sv
// Port-level checks of the Petri net token engine, bound to its top level.
// Depends on pnte_pkg and on petri_net_token_engine.
module pnte_checker
  import pnte_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // Requests are refused only while a result is held back by the receiver.
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("request refused without a downstream stall");

  // A skipped firing always reports its transition as not enabled.
  a_skip_not_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1] == STATUS_SKIPPED) |-> !m_axis_tdata[0])
    else $error("firing skipped on an enabled transition");

  // Padding bits of the result stay zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:10] == 6'd0)
    else $error("result padding not zero");

endmodule

bind petri_net_token_engine pnte_checker u_pnte_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench of the Petri net token engine: directed and random
// requests, a predictor of the net, and randomized stalls on both sides.
// Depends on pnte_pkg and petri_net_token_engine.
module testbench;
  import pnte_pkg::*;

  localparam int NUM_PLACES      = 16;
  localparam int NUM_TRANSITIONS = 16;
  localparam int COUNT_BITS      = 8;
  localparam int COUNT_MAX       = (1 << COUNT_BITS) - 1;

  localparam int RANDOM_REQUESTS = 1500;
  localparam int PRESSURE_AT     = 300;   // requests accepted before the long hold-off
  localparam int PRESSURE_HOLD   = 60;    // cycles the receiver refuses results
  localparam int DRAIN_CYCLES    = 8;     // margin after the last expected result is taken
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_PRINTED     = 40;

  // Command codes the engine does not implement; they must change nothing.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_W'(CMD_FIRE + 1);
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [IDX_W-1:0]    place;
    logic [IDX_W-1:0]    trans;
    logic [WEIGHT_W-1:0] weight;
  } net_req_t;

  typedef struct packed {
    logic                  enabled;
    logic                  status;
    logic [TOKENS_O_W-1:0] tokens;
  } net_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [3:0] place_index, [7:4] transition_index, [15:8] arc_weight
  logic [2:0]  s_axis_tuser  = '0;   // [2:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [0] enabled, [1] status, [9:2] place_tokens, [15:10] zero

  petri_net_token_engine #(
    .NUM_PLACES      (NUM_PLACES),
    .NUM_TRANSITIONS (NUM_TRANSITIONS),
    .COUNT_BITS      (COUNT_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Requests waiting to be offered, and results the net model says must come.
  net_req_t    pending_reqs[$];
  net_result_t expected_results[$];

  // The testbench's own copy of the net.
  logic [WEIGHT_W-1:0] net_in_w  [NUM_PLACES][NUM_TRANSITIONS];
  logic [WEIGHT_W-1:0] net_out_w [NUM_PLACES][NUM_TRANSITIONS];
  int                  net_tokens[NUM_PLACES];

  int mismatch_count = 0;
  int req_count      = 0;
  int result_count   = 0;
  int fired_count    = 0;
  int skipped_count  = 0;
  int clamp_count    = 0;
  int idle_cycles    = 0;

  int   send_gap     = 0;
  int   send_calm    = 0;
  int   recv_wait    = 0;
  int   recv_calm    = 0;
  int   press_left   = 0;
  bit   press_done   = 1'b0;
  logic pressure_on  = 1'b0;

  net_req_t    offer_req;
  net_req_t    taken_req;
  net_result_t taken_res;
  net_result_t want_res;

  // ------------------------------------------------------------------------
  // Net model. It steps once per accepted request, in acceptance order, and
  // returns the one result that the request must produce.
  // ------------------------------------------------------------------------
  task automatic step_net(input net_req_t rq, output net_result_t rs);
    bit p_ok;
    bit t_ok;
    bit en;
    int p;
    int sum;
    p_ok = rq.place < NUM_PLACES;
    t_ok = rq.trans < NUM_TRANSITIONS;
    // Enabled means every place covers its input arc; this is judged before
    // the request changes anything, whatever the command.
    en = t_ok;
    if (t_ok) begin
      for (p = 0; p < NUM_PLACES; p++) begin
        if (net_tokens[p] < net_in_w[p][rq.trans]) en = 1'b0;
      end
    end
    rs.status = STATUS_DONE;
    case (rq.cmd)
      CMD_SET_IN: begin
        if (p_ok && t_ok) net_in_w[rq.place][rq.trans] = rq.weight;
      end
      CMD_SET_OUT: begin
        if (p_ok && t_ok) net_out_w[rq.place][rq.trans] = rq.weight;
      end
      CMD_ADD_TOKEN: begin
        if (p_ok) begin
          if (net_tokens[rq.place] == COUNT_MAX) clamp_count++;
          else net_tokens[rq.place]++;
        end
      end
      CMD_FIRE: begin
        if (en) begin
          // All places move at once: take the input weights, add the output
          // weights, and clamp at the top of the count range.
          fired_count++;
          for (p = 0; p < NUM_PLACES; p++) begin
            sum = net_tokens[p] - net_in_w[p][rq.trans] + net_out_w[p][rq.trans];
            if (sum > COUNT_MAX) begin
              sum = COUNT_MAX;
              clamp_count++;
            end
            net_tokens[p] = sum;
          end
        end else begin
          skipped_count++;
          rs.status = STATUS_SKIPPED;
        end
      end
      default: ;
    endcase
    rs.enabled = en;
    rs.tokens  = p_ok ? TOKENS_O_W'(net_tokens[rq.place]) : '0;
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_PRINTED)
      $display("mismatch in %s at result %0d: got %0d, want %0d",
               what, result_count, got, want);
    mismatch_count++;
  endtask

  // ------------------------------------------------------------------------
  // Stimulus helpers.
  // ------------------------------------------------------------------------
  task automatic queue_req(input logic [CMD_W-1:0] c, input int pl, input int tr, input int w);
    net_req_t rq;
    rq.cmd    = c;
    rq.place  = IDX_W'(pl);
    rq.trans  = IDX_W'(tr);
    rq.weight = WEIGHT_W'(w);
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  // Most traffic lands on a handful of places and transitions so that tokens
  // pile up where arcs exist and firings actually go through.
  function automatic int pick_index();
    if ($urandom_range(0, 99) < 70) return $urandom_range(0, 3);
    return $urandom_range(0, 15);
  endfunction

  function automatic int pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(0, 255);
  endfunction

  // Mostly back-to-back, sometimes a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic queue_noise();
    int r;
    r = $urandom_range(0, 99);
    if (r < 14)      queue_req(CMD_SET_IN, pick_index(), pick_index(), pick_weight());
    else if (r < 28) queue_req(CMD_SET_OUT, pick_index(), pick_index(), pick_weight());
    else if (r < 58) queue_req(CMD_ADD_TOKEN, pick_index(), pick_index(), $urandom_range(0, 255));
    else if (r < 68) queue_req(CMD_QUERY, pick_index(), pick_index(), $urandom_range(0, 255));
    else if (r < 94) queue_req(CMD_FIRE, pick_index(), pick_index(), $urandom_range(0, 255));
    else queue_req(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), $urandom_range(0, 15),
                   $urandom_range(0, 15), $urandom_range(0, 255));
  endtask

  // A well-formed firing: wire up a transition, feed its input place, fire it
  // and look at it again. Stray blocking arcs get cleared on the way.
  task automatic queue_firing_sequence();
    int tr;
    int pl;
    int w;
    int k;
    tr = pick_index();
    pl = pick_index();
    w  = $urandom_range(1, 3);
    if ($urandom_range(0, 1) == 1) queue_req(CMD_SET_IN, pick_index(), tr, 0);
    queue_req(CMD_SET_IN, pl, tr, w);
    if ($urandom_range(0, 1) == 1) queue_req(CMD_SET_OUT, pick_index(), tr, pick_weight());
    for (k = 0; k < w; k++) queue_req(CMD_ADD_TOKEN, pl, pick_index(), $urandom_range(0, 255));
    queue_req(CMD_FIRE, pick_index(), tr, $urandom_range(0, 255));
    queue_req(CMD_QUERY, pl, tr, $urandom_range(0, 255));
  endtask

  // ------------------------------------------------------------------------
  // Sender. Offers the queued requests with random gaps; a request stays on
  // the bus until the engine takes it. During the receiver's long hold-off
  // it offers without gaps so that the engine backs up.
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap > 0 && !pressure_on) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        offer_req = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {offer_req.weight, offer_req.trans, offer_req.place};
        s_axis_tuser  <= offer_req.cmd;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 80);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Every accepted request steps the model and leaves one expected result.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      taken_req.place  = s_axis_tdata[3:0];
      taken_req.trans  = s_axis_tdata[7:4];
      taken_req.weight = s_axis_tdata[15:8];
      taken_req.cmd    = s_axis_tuser;
      step_net(taken_req, taken_res);
      expected_results.insert(expected_results.size(), taken_res);
      req_count <= req_count + 1;
    end
  end

  // ------------------------------------------------------------------------
  // Receiver. Random stalls, calm stretches with tready held high, and one
  // long hold-off once enough requests have gone in.
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (!press_done && req_count >= PRESSURE_AT) begin
        press_done = 1'b1;
        press_left = PRESSURE_HOLD;
      end
      if (press_left > 0) begin
        press_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else if (recv_calm > 0) begin
        recv_calm--;
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) < 30) recv_wait = pick_gap();
        if ($urandom_range(0, 99) == 0) recv_calm = $urandom_range(20, 80);
      end
      pressure_on <= (press_left > 0);
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result with no request pending", m_axis_tdata, 0);
      end else begin
        want_res = expected_results.pop_front();
        if (m_axis_tdata[0] !== want_res.enabled)
          flag_mismatch("enabled", m_axis_tdata[0], want_res.enabled);
        if (m_axis_tdata[1] !== want_res.status)
          flag_mismatch("status", m_axis_tdata[1], want_res.status);
        if (m_axis_tdata[9:2] !== want_res.tokens)
          flag_mismatch("place_tokens", m_axis_tdata[9:2], want_res.tokens);
        if (m_axis_tdata[15:10] !== '0)
          flag_mismatch("padding bits", m_axis_tdata[15:10], 0);
      end
      result_count++;
    end
  end

  // Watchdog: too long without any handshake on either side ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus and end of run.
  // ------------------------------------------------------------------------
  initial begin : stimulus
    int p;
    int t;
    int directed_total;
    for (p = 0; p < NUM_PLACES; p++) begin
      net_tokens[p] = 0;
      for (t = 0; t < NUM_TRANSITIONS; t++) begin
        net_in_w[p][t]  = '0;
        net_out_w[p][t] = '0;
      end
    end

    // Directed part. A transition with no input arcs is enabled from reset.
    queue_req(CMD_QUERY, 0, 0, 0);
    queue_req(CMD_FIRE, 0, 0, 0);
    // Heaviest arc on the highest indices blocks its transition.
    queue_req(CMD_SET_IN, 15, 15, 255);
    queue_req(CMD_QUERY, 15, 15, 255);
    queue_req(CMD_FIRE, 15, 15, 255);
    // A full-weight output arc drives a place into saturation and keeps it there.
    queue_req(CMD_SET_OUT, 0, 1, 255);
    queue_req(CMD_FIRE, 0, 1, 0);
    queue_req(CMD_FIRE, 0, 1, 0);
    queue_req(CMD_ADD_TOKEN, 0, 1, 0);
    // Firing consumes the input weight; a second try falls short and is skipped.
    queue_req(CMD_SET_IN, 0, 2, 200);
    queue_req(CMD_FIRE, 0, 2, 0);
    queue_req(CMD_FIRE, 0, 2, 0);
    // Removing the blocking arc re-enables the transition.
    queue_req(CMD_SET_IN, 15, 15, 0);
    queue_req(CMD_QUERY, 15, 15, 0);
    // Arc writes followed at once by a firing of the same transition.
    queue_req(CMD_SET_IN, 5, 6, 1);
    queue_req(CMD_FIRE, 5, 6, 0);
    queue_req(CMD_ADD_TOKEN, 5, 6, 0);
    queue_req(CMD_FIRE, 5, 6, 0);
    queue_req(CMD_SET_OUT, 15, 0, 1);
    queue_req(CMD_FIRE, 15, 0, 0);
    // Unused command codes leave the net alone.
    queue_req(CMD_SPARE_LO, 15, 15, 255);
    queue_req(CMD_W'(CMD_SPARE_LO + 1), 3, 0, 170);
    queue_req(CMD_SPARE_HI, 0, 0, 0);
    directed_total = pending_reqs.size();

    // Random part: mostly complete firing sequences, the rest loose requests.
    while (pending_reqs.size() < directed_total + RANDOM_REQUESTS) begin
      if ($urandom_range(0, 99) < 45) queue_firing_sequence();
      else queue_noise();
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d requests and checked %0d results", req_count, result_count);
    $display("firings: %0d taken, %0d skipped; clamped token updates: %0d",
             fired_count, skipped_count, clamp_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
